### rtl/core/iir3z1p_pkg.sv
// shared types and constants for the three-zero one-pole iir filter
// no dependencies; used by the coefficient bank, the mac and the top level

package iir3z1p_pkg;

  // coefficient word width, unsigned fraction
  localparam int unsigned GainWidth = 16;

  // configuration register index width
  localparam int unsigned CfgIdxWidth = 2;

  // register map
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgGainCurrent  = 2'd0,
    CfgGainPrev     = 2'd1,
    CfgGainPrev2    = 2'd2,
    CfgGainFeedback = 2'd3
  } cfg_reg_e;

  // coefficient values after reset
  localparam logic [GainWidth-1:0] GainCurrentRst  = 16'd20480;  // 0.3125
  localparam logic [GainWidth-1:0] GainPrevRst     = 16'd15754;  // about 0.240385
  localparam logic [GainWidth-1:0] GainPrev2Rst    = 16'd20480;  // 0.3125
  localparam logic [GainWidth-1:0] GainFeedbackRst = 16'd19456;  // 0.296875

  // the four coefficients as one bundle
  typedef struct packed {
    logic [GainWidth-1:0] current;
    logic [GainWidth-1:0] prev;
    logic [GainWidth-1:0] prev2;
    logic [GainWidth-1:0] feedback;
  } gains_t;

endpackage

### rtl/core/iir3z1p_if.sv
// valid/ready stream interfaces for the input and result words
// no dependencies

interface iir3z1p_in_if #(
  parameter int unsigned SampleWidth = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir3z1p_out_if #(
  parameter int unsigned SampleWidth = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/core/iir_filter_three_zero_one_pole.sv
// top level of the three-zero one-pole iir filter: handshake, sample history, output register
// depends on iir3z1p_pkg, iir3z1p_if, iir3z1p_cfg and iir3z1p_mac

// Direct-form-1 filter on unsigned samples: each result word is
// (c0*x + c1*x1 + c2*x2 + c3*y1) >> COEF_FRAC_BITS, saturated at 2^SAMPLE_WIDTH-1,
// where x1/x2 are the two previous input words and y1 is the previous (saturated)
// result. One result word is produced per input word. A word is captured in an
// input register, goes combinationally through the four multipliers, the adder tree
// and the clamp, and moves into the output register once the output is not stalled.
// Throughput is one word per clock while the output is not stalled: the feedback
// loop from the previous output value through the feedback multiplier and adder tree
// back to the history register is combinational, so that path sets the clock limit.
// While the output register holds a word that the sink has not yet taken, input
// ready stays high only as long as the input register is empty; with both registers
// full, a stalled output holds off the input. Coefficients (unsigned Q0.COEF_FRAC_BITS,
// 16 bits wide) are written through cfg_we_i/cfg_idx_i/cfg_data_i and should only be
// changed while no word is in flight. Reset clears the sample history and loads the
// default coefficients.

module iir_filter_three_zero_one_pole #(
  parameter int unsigned SAMPLE_WIDTH   = 12,
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iir3z1p_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [iir3z1p_pkg::GainWidth-1:0]   cfg_data_i,
  iir3z1p_in_if.sink                          in_i,
  iir3z1p_out_if.source                       out_o
);

  iir3z1p_pkg::gains_t gains;

  // input stage
  logic                    in_valid_q;
  logic [SAMPLE_WIDTH-1:0] x_q;

  // sample history, advanced when a word moves to the output register
  logic [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q;

  // output stage
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] y_q;
  logic [SAMPLE_WIDTH-1:0] y_d;

  logic out_free;   // output register can take a word this cycle
  logic advance;    // input-stage word moves to the output register
  logic in_free;    // input register can take a word this cycle
  logic in_take;

  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && out_free;
  assign in_free  = !in_valid_q || out_free;
  assign in_take  = in_i.valid && in_free;

  assign in_i.ready = in_free;

  iir3z1p_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .gains_o    (gains)
  );

  iir3z1p_mac #(
    .SampleWidth  (SAMPLE_WIDTH),
    .CoefFracBits (COEF_FRAC_BITS)
  ) u_mac (
    .gains_i (gains),
    .x_i     (x_q),
    .x1_i    (x1_q),
    .x2_i    (x2_q),
    .y1_i    (y1_q),
    .y_o     (y_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // history is filter state and must start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
    end else if (advance) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y1_q <= y_d;   // saturated value is what feeds back
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q <= in_i.sample_in;
    end
    if (advance) begin
      y_q <= y_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = y_q;

endmodule

### rtl/core/iir3z1p_cfg.sv
// coefficient register bank, written through a plain write port
// depends on iir3z1p_pkg

module iir3z1p_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iir3z1p_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [iir3z1p_pkg::GainWidth-1:0]    cfg_data_i,
  output iir3z1p_pkg::gains_t                  gains_o
);

  iir3z1p_pkg::gains_t gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.current  <= iir3z1p_pkg::GainCurrentRst;
      gains_q.prev     <= iir3z1p_pkg::GainPrevRst;
      gains_q.prev2    <= iir3z1p_pkg::GainPrev2Rst;
      gains_q.feedback <= iir3z1p_pkg::GainFeedbackRst;
    end else if (cfg_we_i) begin
      case (iir3z1p_pkg::cfg_reg_e'(cfg_idx_i))
        iir3z1p_pkg::CfgGainCurrent:  gains_q.current  <= cfg_data_i;
        iir3z1p_pkg::CfgGainPrev:     gains_q.prev     <= cfg_data_i;
        iir3z1p_pkg::CfgGainPrev2:    gains_q.prev2    <= cfg_data_i;
        iir3z1p_pkg::CfgGainFeedback: gains_q.feedback <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gains_o = gains_q;

endmodule

### rtl/core/iir3z1p_mac.sv
// four-tap multiply-accumulate with truncating shift and saturation
// depends on iir3z1p_pkg

module iir3z1p_mac #(
  parameter int unsigned SampleWidth  = 12,
  parameter int unsigned CoefFracBits = 16
) (
  input  iir3z1p_pkg::gains_t     gains_i,
  input  logic [SampleWidth-1:0]  x_i,
  input  logic [SampleWidth-1:0]  x1_i,
  input  logic [SampleWidth-1:0]  x2_i,
  input  logic [SampleWidth-1:0]  y1_i,
  output logic [SampleWidth-1:0]  y_o
);

  localparam int unsigned ProdWidth = iir3z1p_pkg::GainWidth + SampleWidth;
  // two guard bits cover the sum of four products
  localparam int unsigned AccWidth  = ProdWidth + 2;

  localparam logic [AccWidth-1:0] SampleMax = AccWidth'({SampleWidth{1'b1}});

  logic [ProdWidth-1:0] prod_x, prod_x1, prod_x2, prod_y1;
  logic [AccWidth-1:0]  acc;
  logic [AccWidth-1:0]  acc_shr;

  always_comb begin
    prod_x  = ProdWidth'(gains_i.current)  * ProdWidth'(x_i);
    prod_x1 = ProdWidth'(gains_i.prev)     * ProdWidth'(x1_i);
    prod_x2 = ProdWidth'(gains_i.prev2)    * ProdWidth'(x2_i);
    prod_y1 = ProdWidth'(gains_i.feedback) * ProdWidth'(y1_i);

    acc = (AccWidth'(prod_x) + AccWidth'(prod_x1))
        + (AccWidth'(prod_x2) + AccWidth'(prod_y1));

    // sum is never negative, so a plain shift truncates toward zero
    acc_shr = acc >> CoefFracBits;

    if (acc_shr > SampleMax) begin
      y_o = {SampleWidth{1'b1}};
    end else begin
      y_o = acc_shr[SampleWidth-1:0];
    end
  end

endmodule
